>>> hdl/swept_box_box_entry_time_top_assert.svh
// ----------------------------------------------------------------------------
// swept box entry time assertion macros
// clocked property checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SWEPT_BOX_BOX_ENTRY_TIME_TOP_ASSERT_SVH
`define SWEPT_BOX_BOX_ENTRY_TIME_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SBET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define SBET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBET_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/sbet_pkg.sv
// ----------------------------------------------------------------------------
// sbet_pkg
// shared constants and types of the swept box entry time block
// ----------------------------------------------------------------------------
`default_nettype none

package sbet_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // result time is always reported with 16 fraction bits
  localparam int OUT_FRAC_BITS = 16;
  localparam int ENTRY_W       = OUT_FRAC_BITS + 1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/sbet_div.sv
// ----------------------------------------------------------------------------
// sbet_div
// shared restoring divider, one quotient bit per cycle, saturates to +-2.0
// ----------------------------------------------------------------------------
`default_nettype none

module sbet_div #(
  parameter int COORD_WIDTH = sbet_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = sbet_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic signed [COORD_WIDTH:0] num,
  input  wire logic signed [COORD_WIDTH:0] den,
  output sbet_pkg::div_stat_t              stat,
  output logic signed [FRAC_BITS+2:0]      quot
);

  localparam int NW    = COORD_WIDTH + 1;
  localparam int RW    = COORD_WIDTH + 2;
  localparam int QW    = FRAC_BITS + 2;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  localparam logic [QW-1:0] LIM = {2'b10, {FRAC_BITS{1'b0}}};

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [NW-1:0]    ud_r, ud_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             done_r, done_nxt;

  logic [NW-1:0] num_mag, den_mag;
  logic [RW-1:0] rem_sh, ud_ext;
  logic [QW-1:0] q_sh;

  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = den[NW-1] ? NW'(-den) : NW'(den);
  assign ud_ext  = {1'b0, ud_r};

  // first step compares without a shift
  assign rem_sh = (cnt_r == '0) ? rem_r : {rem_r[RW-2:0], 1'b0};
  assign q_sh   = (cnt_r == '0) ? q_r : {q_r[QW-2:0], 1'b0};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    ud_nxt    = ud_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          neg_nxt   = num[NW-1] != den[NW-1];
          ud_nxt    = den_mag;
          rem_nxt   = {1'b0, num_mag};
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = D_CHK;
        end
      end
      D_CHK: begin
        if (rem_r >= {ud_r, 1'b0}) begin
          q_nxt     = LIM;
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          state_nxt = D_RUN;
        end
      end
      D_RUN: begin
        if (rem_sh >= ud_ext) begin
          rem_nxt = rem_sh - ud_ext;
          q_nxt   = q_sh | QW'(1);
        end else begin
          rem_nxt = rem_sh;
          q_nxt   = q_sh;
        end
        if (cnt_r == CNT_W'(FRAC_BITS)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    ud_r  <= ud_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy = state_r != D_IDLE;
  assign stat.done = done_r;
  assign quot      = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

`default_nettype wire

>>> hdl/swept_box_box_entry_time_top.sv
// ----------------------------------------------------------------------------
// swept_box_box_entry_time_top
// swept axis-aligned box test, one axis per transfer, result on the last axis
// ----------------------------------------------------------------------------
// datapath: each axis runs two slab divisions on one shared divider that makes one
//   quotient bit a cycle; zero relative speed or an axis after a miss skips both
//   divisions, and a saturated quotient ends its division early
// throughput: one axis at a time, in_ready only between axes
// reset: interval back to [0, 1], miss flag and output valid cleared
`default_nettype none

`include "swept_box_box_entry_time_top_assert.svh"

module swept_box_box_entry_time_top #(
  parameter int COORD_WIDTH = sbet_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = sbet_pkg::DEF_FRAC_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_min,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_max,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_vel,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_min,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_max,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_vel,
  input  wire logic                          in_last_axis,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_hit,
  output logic [sbet_pkg::ENTRY_W-1:0]       out_entry_time
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int TW    = FRAC_BITS + 3;
  localparam int SHR   = (FRAC_BITS >= sbet_pkg::OUT_FRAC_BITS) ?
                         (FRAC_BITS - sbet_pkg::OUT_FRAC_BITS) : 0;
  localparam int SHL   = (FRAC_BITS >= sbet_pkg::OUT_FRAC_BITS) ?
                         0 : (sbet_pkg::OUT_FRAC_BITS - FRAC_BITS);
  localparam int EXT_W = TW + sbet_pkg::OUT_FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIVA = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;

  logic [2:0]             state_r, state_nxt;
  logic signed [DW-1:0]   d_r, n1_r, n2_r;
  logic                   last_r;
  logic signed [TW-1:0]   a_r, b_r;
  logic signed [TW-1:0]   enter_r, enter_nxt;
  logic signed [TW-1:0]   exit_r, exit_nxt;
  logic                   missed_r, missed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r;
  logic [sbet_pkg::ENTRY_W-1:0] out_et_r;

  logic                   in_xfer, load_out;
  logic                   div_start;
  logic signed [DW-1:0]   div_num;
  sbet_pkg::div_stat_t    div_stat;
  logic signed [TW-1:0]   div_quot;

  logic signed [TW-1:0]   lo, hi;
  logic                   missed_fin, hit_fin;
  logic [EXT_W-1:0]       et_ext;
  logic [sbet_pkg::ENTRY_W-1:0] et_fin;

  assign in_ready = state_r == S_IDLE;
  assign in_xfer  = in_valid && in_ready;

  assign div_num = (state_r == S_EVAL) ? n1_r : n2_r;

  sbet_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (d_r),
    .stat (div_stat),
    .quot (div_quot)
  );

  // slab times in order
  assign lo = (a_r > b_r) ? b_r : a_r;
  assign hi = (a_r > b_r) ? a_r : b_r;

  // a narrowed interval never passes the miss check with enter above exit
  assign missed_fin = missed_r || (enter_r > exit_r);
  assign hit_fin    = !missed_fin && (enter_r > TW'(0));
  assign et_ext     = (EXT_W'($unsigned(enter_r)) << SHL) >> SHR;
  assign et_fin     = hit_fin ? et_ext[sbet_pkg::ENTRY_W-1:0] : '0;

  always_comb begin
    state_nxt     = state_r;
    enter_nxt     = enter_r;
    exit_nxt      = exit_r;
    missed_nxt    = missed_r;
    div_start     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (missed_r) begin
          state_nxt = S_FIN;
        end else if (d_r == '0) begin
          // touching at zero speed counts as a miss
          if (!n1_r[DW-1] || n2_r[DW-1] || (n2_r == '0)) begin
            missed_nxt = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIVA;
        end
      end
      S_DIVA: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          state_nxt = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_stat.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (lo > enter_r) begin
          enter_nxt = lo;
        end
        if (hi < exit_r) begin
          exit_nxt = hi;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          missed_nxt = missed_fin;
          state_nxt  = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          enter_nxt     = '0;
          exit_nxt      = ONE;
          missed_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enter_r     <= '0;
      exit_r      <= ONE;
      missed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enter_r     <= enter_nxt;
      exit_r      <= exit_nxt;
      missed_r    <= missed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_xfer) begin
      d_r    <= DW'(in_second_vel) - DW'(in_first_vel);
      n1_r   <= DW'(in_first_min) - DW'(in_second_max);
      n2_r   <= DW'(in_first_max) - DW'(in_second_min);
      last_r <= in_last_axis;
    end
    if (state_r == S_DIVA && div_stat.done) begin
      a_r <= div_quot;
    end
    if (state_r == S_DIVB && div_stat.done) begin
      b_r <= div_quot;
    end
    if (load_out) begin
      out_hit_r <= hit_fin;
      out_et_r  <= et_fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_entry_time = out_et_r;

  `SBET_ASSERT_IMPL(a_div_idle_start, div_start, !div_stat.busy, "divider started while busy")
  `SBET_ASSERT_IMPL(a_enter_nonneg, 1'b1, !enter_r[TW-1], "entry time went negative")
  `SBET_ASSERT_IMPL(a_nohit_zero, out_valid_r && !out_hit_r, out_et_r == '0, "miss with time")
  `SBET_ASSERT_NEXT(a_fin_last_done, state_r == S_FIN && last_r && load_out,
                    out_valid_r && state_r == S_IDLE && !missed_r && enter_r == '0,
                    "query end did not reset")

endmodule

`default_nettype wire
